// ----- rtl/knap_pkg.sv -----
// shared widths and constants of the knapsack profit unit
package knap_pkg;

   localparam int WEIGHT_W = 10;
   localparam int ITEM_PROFIT_W = 16;
   localparam int LIMIT_W = 10;
   localparam int PROFIT_W = 32;

   localparam logic [PROFIT_W-1:0] PROFIT_TOP = {PROFIT_W{1'b1}};

   typedef logic [PROFIT_W-1:0] profit_type;

   // saturating add of an item profit onto a row entry
   function automatic profit_type sat_add(input profit_type base,
                                          input logic [ITEM_PROFIT_W-1:0] gain);
      logic [PROFIT_W:0] sum;
      sum = {1'b0, base} + {{(PROFIT_W + 1 - ITEM_PROFIT_W){1'b0}}, gain};
      return sum[PROFIT_W] ? PROFIT_TOP : sum[PROFIT_W-1:0];
   endfunction

endpackage

// ----- rtl/knapsack_01_max_profit_unit.sv -----
// top level of the 0/1 knapsack best-profit unit
//
// 0/1 knapsack solver: each req beat carries one item (weight, profit, last
// mark). The unit holds a row of best profits, one 32-bit entry per capacity
// 0..CAP_MAX, in a ram with one write and two read ports. An item walks the
// row from CAP_MAX down to 0, one entry per cycle: read best[c] and
// best[c-w], then in the next cycle write max(best[c], profit + best[c-w])
// with the sum saturating at all ones. An item therefore stalls the input
// through the walk and the drain state, so a new item is taken only once
// the single pass over the row is done. On a beat marked last the entry at
// capacity_limit (clamped to CAP_MAX) moves to the output register once that
// register is free (it waits while an earlier result is still stalled there)
// and is returned as one rsp beat, then the row is cleared one entry per
// cycle; the same clearing pass runs after reset, during which no item is
// taken (csr writes are always taken). A waiting result sits in an output
// register, so the next problem can start while it is not yet taken.
module knapsack_01_max_profit_unit
   import knap_pkg::*;
#(
   parameter int CAP_MAX = 1023
) (
   input  logic                     clock,
   input  logic                     reset,
   // item beats
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [WEIGHT_W-1:0]      req_item_weight,
   input  logic [ITEM_PROFIT_W-1:0] req_item_profit,
   input  logic                     req_last_item,
   // result beats
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [PROFIT_W-1:0]      rsp_best_profit,
   // capacity limit register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [LIMIT_W-1:0]       csr_capacity_limit
);

   localparam int DEPTH = CAP_MAX + 1;
   localparam int AW = $clog2(DEPTH);
   // compare width that holds both a row index and a weight or limit
   localparam int CW = (AW > WEIGHT_W) ? ((AW > LIMIT_W) ? AW : LIMIT_W)
                                        : ((WEIGHT_W > LIMIT_W) ? WEIGHT_W : LIMIT_W);
   localparam logic [AW-1:0] TOP_ADDR = AW'(CAP_MAX);
   localparam logic [CW-1:0] TOP_CMP = CW'(CAP_MAX);

   localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
   localparam logic [2:0] ST_WALK = 3'd1;  // issuing reads, high to low
   localparam logic [2:0] ST_DRAIN = 3'd2; // last write of the walk
   localparam logic [2:0] ST_DONE = 3'd3;  // result waits for the output register
   localparam logic [2:0] ST_CLEAR = 3'd4; // zeroing the row

   logic [2:0]               state_ff, state_in;
   logic [AW-1:0]            cap_ff, cap_in;      // walk and clear pointer
   logic [WEIGHT_W-1:0]      weight_ff, weight_in;
   logic [ITEM_PROFIT_W-1:0] profit_ff, profit_in;
   logic                     last_ff, last_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;

   // update stage, aligned with the ram read data
   logic          upd_vld_ff, upd_vld_in;
   logic [AW-1:0] upd_addr_ff, upd_addr_in;
   logic          upd_take_ff, upd_take_in;

   profit_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   profit_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0] cap_ext, weight_ext, limit_ext, diff_ext;
   logic [AW-1:0] limit_addr;
   logic          fits;
   logic          out_free;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   profit_type    ram_wr_data;
   logic [AW-1:0] ram_rd_b_addr;
   profit_type    cur_entry, src_entry, cand, upd_val;

   knap_ram #(
      .WIDTH (PROFIT_W),
      .DEPTH (DEPTH)
   ) u_row (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_addr (cap_ff),
      .rd_a_data (cur_entry),
      .rd_b_addr (ram_rd_b_addr),
      .rd_b_data (src_entry)
   );

   // index arithmetic for the read side
   always_comb begin
      cap_ext = CW'(cap_ff);
      weight_ext = CW'(weight_ff);
      limit_ext = CW'(limit_ff);
      fits = (weight_ext <= cap_ext);
      diff_ext = cap_ext - weight_ext;
      ram_rd_b_addr = fits ? diff_ext[AW-1:0] : cap_ff;
      limit_addr = (limit_ext > TOP_CMP) ? TOP_ADDR : limit_ext[AW-1:0];
   end

   // the walk only reads entries below the one being written, so reads and
   // the pending write never meet at the same entry
   always_comb begin
      cand = sat_add(src_entry, profit_ff);
      upd_val = (upd_take_ff && (cand > cur_entry)) ? cand : cur_entry;
      ram_wr_en = upd_vld_ff || (state_ff == ST_CLEAR);
      ram_wr_addr = upd_vld_ff ? upd_addr_ff : cap_ff;
      ram_wr_data = upd_vld_ff ? upd_val : '0;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cap_in = cap_ff;
      weight_in = weight_ff;
      profit_in = profit_ff;
      last_in = last_ff;
      limit_in = limit_ff;
      upd_vld_in = (state_ff == ST_WALK);
      upd_addr_in = cap_ff;
      upd_take_in = fits;
      result_in = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;

      if (csr_valid) begin
         limit_in = csr_capacity_limit;
      end

      // keep the final value of the reported entry as the walk writes it
      if (upd_vld_ff && (upd_addr_ff == limit_addr)) begin
         result_in = upd_val;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               weight_in = req_item_weight;
               profit_in = req_item_profit;
               last_in = req_last_item;
               cap_in = TOP_ADDR;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cap_in = cap_ff - AW'(1);
            if (cap_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = result_ff;
               cap_in = TOP_ADDR;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            cap_in = cap_ff - AW'(1);
            if (cap_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cap_in = TOP_ADDR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cap_ff <= TOP_ADDR;
         limit_ff <= '0;
         upd_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff <= cap_in;
         limit_ff <= limit_in;
         upd_vld_ff <= upd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      weight_ff <= weight_in;
      profit_ff <= profit_in;
      last_ff <= last_in;
      upd_addr_ff <= upd_addr_in;
      upd_take_ff <= upd_take_in;
      result_ff <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_best_profit = rsp_data_ff;

endmodule

// ----- rtl/knap_ram.sv -----
// generic ram: one write port, two read ports, registered read data
module knap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ----- rtl/knap_checker.sv -----
// port checker for the knapsack profit unit, bound to the top level
module knap_checker
   import knap_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [PROFIT_W-1:0] rsp_best_profit
);

   // reset starts the clearing pass, so no item is taken right after it
   a_reset_busy: assert property (@(posedge clock) reset |=> req_stall)
      else $error("item input open right after reset");

   // an accepted item occupies the unit for the walk over the row
   a_item_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item input open right after an item beat");

   // a new result only appears while the row is being cleared
   a_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result raised while item input open");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_best_profit)))
      else $error("stalled result beat dropped or changed");

endmodule

bind knapsack_01_max_profit_unit knap_checker u_knap_checker (.*);
